>>> src/sobel_pkg.sv
// Shared types, constants and gradient functions for the Sobel edge threshold block.
`timescale 1ns / 1ps

package sobel_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int WIDTH_W = 10;
  localparam int THR_W   = 11;
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;
  localparam int MAG_W   = 21;
  localparam int CFG_W   = 11;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(512);
  localparam int                 THR_DEFAULT  = 38;
  localparam logic [MAG_W-1:0]   THR_CMP_RESET =
    MAG_W'(THR_DEFAULT * THR_DEFAULT - THR_DEFAULT + 1);

  localparam logic [PIX_W-1:0] PIX_EDGE    = PIX_W'(0);
  localparam logic [PIX_W-1:0] PIX_NO_EDGE = PIX_W'(255);

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH    = 1'b0;
  localparam logic REG_EDGE_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_FULL
  } phase_t;

  // One column of the 3x3 window, top to bottom.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  function automatic logic signed [GRAD_W-1:0] col_weight(input col_t c);
    logic [GRAD_W-1:0] s;
    s = GRAD_W'(c.top) + (GRAD_W'(c.mid) << 1) + GRAD_W'(c.bot);
    return $signed(s);
  endfunction

  function automatic logic signed [GRAD_W-1:0] sobel_gx(input col_t l, input col_t r);
    return col_weight(r) - col_weight(l);
  endfunction

  function automatic logic signed [GRAD_W-1:0] sobel_gy(input col_t l, input col_t c,
                                                        input col_t r);
    logic [GRAD_W-1:0] bot_sum;
    logic [GRAD_W-1:0] top_sum;
    bot_sum = GRAD_W'(l.bot) + (GRAD_W'(c.bot) << 1) + GRAD_W'(r.bot);
    top_sum = GRAD_W'(l.top) + (GRAD_W'(c.top) << 1) + GRAD_W'(r.top);
    return $signed(bot_sum - top_sum);
  endfunction

endpackage

>>> src/sobel_edge_threshold.sv
// Streaming 3x3 Sobel edge detector with threshold, line stores and result pipeline.
//
// Pixels enter one beat at a time in raster order on in_valid/in_stall, with
// mode 0 for a pixel and mode 1 for a flush tick. After the last row, send
// image_width flush ticks to emit that row; the final result carries frame_last.
// Results leave on out_valid/out_stall: pixel_out is 0 on an edge, 255 elsewhere.
// The first row gives no results; each later beat gives one result, the first
// beat of a row gives none and the last beat of a row gives two.
// A result passes from the first stage registers through the squared magnitude
// register to the output register; the second result of a row end follows the first.
// One beat is taken per cycle while in_stall is low; the single result path takes
// one result per cycle when not stalled, so a row-end beat holds in_stall high until its first result moves on.
// The line stores are read one column ahead so that their registered read data
// is ready when the next beat arrives.
// The user writes configuration (image_width, edge_threshold) through cfg_wr_en,
// cfg_index and cfg_data only while the block is idle, which it does not enforce.
// Reset (synchronous, rst high) empties the pipeline, clears the window and
// column count, and waits for a first row; line store contents are kept.
// When out_stall is high the output register holds; the pipeline behind it
// fills and then in_stall rises until the output moves again.
`timescale 1ns / 1ps

module sobel_edge_threshold
  import sobel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last
);

  logic [WIDTH_W-1:0] image_width;
  logic [MAG_W-1:0]   thr_cmp;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_upper;
  logic [PIX_W-1:0] rd_lower;
  logic [COL_W-1:0] rd_addr;

  col_t             win [3];
  col_t             win_next [3];
  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_next;
  phase_t           row_phase;
  phase_t           row_phase_next;

  // First stage: gradients of up to two windows per beat.
  logic                     pend0;
  logic                     pend1;
  logic                     s1_last;
  logic signed [GRAD_W-1:0] gx_a, gy_a, gx_b, gy_b;

  logic             s2_valid;
  logic             s2_last;
  logic [MAG_W-1:0] mag2;

  logic             accept;
  logic             ignore;
  logic             row_end;
  logic             emit_a;
  logic             emit_b;
  logic [COL_W-1:0] last_col;
  logic [PIX_W-1:0] top_pix, mid_pix, bot_pix;
  col_t             new_col;
  logic signed [GRAD_W-1:0] gx_a_next, gy_a_next, gx_b_next, gy_b_next;

  logic                     out_ready;
  logic                     s2_ready;
  logic                     issue;
  logic                     s1_free;
  logic signed [GRAD_W-1:0] gx_sel, gy_sel;
  logic signed [2*GRAD_W-1:0] sq_x, sq_y;
  logic [2*GRAD_W-1:0]      mag_sum;
  logic [2*THR_W-1:0]       thr_sq;
  logic [2*THR_W-1:0]       thr_full;

  // Configuration registers; the threshold is kept as T*T - T + 1 (zero for T = 0).
  always_comb begin
    thr_sq   = cfg_data[THR_W-1:0] * cfg_data[THR_W-1:0];
    thr_full = thr_sq - (2*THR_W)'(cfg_data[THR_W-1:0]) + (2*THR_W)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      thr_cmp     <= THR_CMP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[WIDTH_W-1:0];
        end
        REG_EDGE_THRESHOLD: begin
          if (cfg_data[THR_W-1:0] == '0) begin
            thr_cmp <= '0;
          end else if (thr_full[2*THR_W-1:MAG_W] != '0) begin
            // Above every reachable magnitude, so no pixel is an edge.
            thr_cmp <= '1;
          end else begin
            thr_cmp <= thr_full[MAG_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake and pipeline flow.
  always_comb begin
    out_ready = !out_valid || !out_stall;
    s2_ready  = !s2_valid || out_ready;
    issue     = (pend0 || pend1) && s2_ready;
    s1_free   = !(pend0 || pend1) || (s2_ready && (pend0 ^ pend1));
    in_stall  = !s1_free;
    accept    = in_valid && s1_free;
  end

  // Column and window control.
  always_comb begin
    if (image_width < WIDTH_W'(2)) begin
      last_col = COL_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(image_width - WIDTH_W'(1));
    end
    row_end = column_count >= last_col;
    ignore  = (row_phase == PH_EMPTY) && mode;

    mid_pix = rd_lower;
    top_pix = (row_phase == PH_ONE) ? mid_pix : rd_upper;
    bot_pix = mode ? mid_pix : pixel_in;
    new_col = '{top: top_pix, mid: mid_pix, bot: bot_pix};

    emit_a = (row_phase != PH_EMPTY) && (column_count != '0);
    emit_b = (row_phase != PH_EMPTY) && row_end;

    // Window after the first shift is (win[1], win[2], new); after the second
    // shift at a row end it is (win[2], new, new).
    gx_a_next = sobel_gx(win[1], new_col);
    gy_a_next = sobel_gy(win[1], win[2], new_col);
    gx_b_next = sobel_gx(win[2], new_col);
    gy_b_next = sobel_gy(win[2], new_col, new_col);

    if (ignore) begin
      column_next = column_count;
    end else if (row_end) begin
      column_next = '0;
    end else begin
      column_next = column_count + COL_W'(1);
    end
    rd_addr = accept ? column_next : column_count;
  end

  always_comb begin
    row_phase_next = row_phase;
    if (accept && !ignore && row_end) begin
      if (mode) begin
        row_phase_next = PH_EMPTY;
      end else if (row_phase == PH_EMPTY) begin
        row_phase_next = PH_ONE;
      end else begin
        row_phase_next = PH_FULL;
      end
    end
  end

  always_comb begin
    win_next = win;
    if (row_phase != PH_EMPTY) begin
      if (column_count == '0) begin
        win_next[0] = new_col;
        win_next[1] = new_col;
        win_next[2] = new_col;
      end else if (row_end) begin
        win_next[0] = win[2];
        win_next[1] = new_col;
        win_next[2] = new_col;
      end else begin
        win_next[0] = win[1];
        win_next[1] = win[2];
        win_next[2] = new_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= PH_EMPTY;
      win[0]       <= '0;
      win[1]       <= '0;
      win[2]       <= '0;
    end else if (accept) begin
      column_count <= column_next;
      row_phase    <= row_phase_next;
      win          <= win_next;
    end
  end

  // Line stores: written at the current column, read one column ahead.
  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      if (row_phase == PH_EMPTY) begin
        lower_mem[column_count] <= pixel_in;
      end else begin
        upper_mem[column_count] <= mid_pix;
        lower_mem[column_count] <= bot_pix;
      end
    end
    rd_upper <= upper_mem[rd_addr];
    rd_lower <= lower_mem[rd_addr];
  end

  // First stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend0 <= 1'b0;
      pend1 <= 1'b0;
    end else if (accept) begin
      pend0 <= emit_a;
      pend1 <= emit_b;
    end else if (issue) begin
      if (pend0) begin
        pend0 <= 1'b0;
      end else begin
        pend1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gx_a    <= gx_a_next;
      gy_a    <= gy_a_next;
      gx_b    <= gx_b_next;
      gy_b    <= gy_b_next;
      s1_last <= mode;
    end
  end

  // Second stage: squared magnitude of one result per cycle while s2_ready is high.
  always_comb begin
    gx_sel  = pend0 ? gx_a : gx_b;
    gy_sel  = pend0 ? gy_a : gy_b;
    sq_x    = gx_sel * gx_sel;
    sq_y    = gy_sel * gy_sel;
    mag_sum = $unsigned(sq_x) + $unsigned(sq_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= pend0 || pend1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mag2    <= mag_sum[MAG_W-1:0];
      s2_last <= !pend0 && s1_last;
    end
  end

  // Output register: threshold compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_ready) begin
      pixel_out  <= (mag2 >= thr_cmp) ? PIX_EDGE : PIX_NO_EDGE;
      frame_last <= s2_last;
    end
  end

endmodule

>>> bench/tb_sobel_edge_threshold.sv
// Self-checking testbench for the streaming Sobel edge threshold block.
`timescale 1ns / 1ps

module tb_sobel_edge_threshold;
  import sobel_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } edge_beat_t;

  // Tracks the line stores and window of the block and queues the edge pixels it must emit.
  class sobel_tracker;
    logic [WIDTH_W-1:0] width_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [PIX_W-1:0]   row_two_back [MAX_WIDTH];
    logic [PIX_W-1:0]   row_one_back [MAX_WIDTH];
    logic [PIX_W-1:0]   win [3][3];
    int                 column;
    phase_t             stage;
    edge_beat_t         edges_due[$];
    int                 beats;
    int                 errors;

    function new();
      int i;
      int r;
      width_reg = WIDTH_RESET;
      thr_reg   = THR_W'(THR_DEFAULT);
      column    = 0;
      stage     = PH_EMPTY;
      beats     = 0;
      errors    = 0;
      for (r = 0; r < 3; r++) begin
        for (i = 0; i < 3; i++) win[r][i] = '0;
      end
      for (i = 0; i < MAX_WIDTH; i++) begin
        row_two_back[i] = '0;
        row_one_back[i] = '0;
      end
    endfunction

    task complain(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    function void write_reg(input logic idx, input logic [CFG_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_W-1:0];
      else thr_reg = data[THR_W-1:0];
    endfunction

    function int row_length();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function void slide(input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] m,
                        input logic [PIX_W-1:0] b);
      int r;
      for (r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = t;
      win[1][2] = m;
      win[2][2] = b;
    endfunction

    function edge_beat_t grade(input logic closes_frame);
      int         gx;
      int         gy;
      longint     mag2;
      longint     t;
      edge_beat_t e;
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      mag2 = longint'(gx) * gx + longint'(gy) * gy;
      t = longint'(thr_reg);
      // Rounded square root at or above T is the same as mag2 >= T*T - T + 1.
      e.pix  = (t == 0 || mag2 >= t * t - t + 1) ? PIX_EDGE : PIX_NO_EDGE;
      e.last = closes_frame;
      return e;
    endfunction

    function void take_beat(input logic flush, input logic [PIX_W-1:0] p);
      int               len;
      int               c;
      int               r;
      bit               row_end;
      logic [PIX_W-1:0] t;
      logic [PIX_W-1:0] m;
      logic [PIX_W-1:0] b;
      len     = row_length();
      c       = (column >= MAX_WIDTH) ? MAX_WIDTH - 1 : column;
      row_end = (c >= len - 1);
      if (stage == PH_EMPTY) begin
        // A flush tick with no stored row leaves no trace.
        if (flush) return;
        row_one_back[c] = p;
      end else begin
        m = row_one_back[c];
        t = (stage == PH_ONE) ? m : row_two_back[c];
        b = flush ? m : p;
        row_two_back[c] = m;
        row_one_back[c] = b;
        if (c == 0) begin
          for (r = 0; r < 3; r++) begin
            win[0][r] = t;
            win[1][r] = m;
            win[2][r] = b;
          end
        end else begin
          slide(t, m, b);
          edges_due.push_back(grade(1'b0));
        end
        if (row_end) begin
          // The right border repeats the last column once more.
          slide(t, m, b);
          edges_due.push_back(grade(flush));
        end
      end
      beats++;
      if (row_end) begin
        column = 0;
        if (flush) stage = PH_EMPTY;
        else if (stage != PH_FULL) stage = phase_t'(stage + 1);
      end else begin
        column = c + 1;
      end
    endfunction

    task match_pixel(input logic [PIX_W-1:0] p, input logic last);
      edge_beat_t e;
      if (edges_due.size() == 0) begin
        complain($sformatf("result with none expected: pixel_out=%0d frame_last=%0b",
                           p, last));
        return;
      end
      e = edges_due.pop_front();
      if (p !== e.pix)
        complain($sformatf("pixel_out=%0d, expected %0d", p, e.pix));
      if (last !== e.last)
        complain($sformatf("frame_last=%0b, expected %0b", last, e.last));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             mode      = 1'b0;
  logic [PIX_W-1:0] pixel_in  = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  int           gap_pct   = 0;
  int           stall_pct = 0;
  bit           calm      = 1'b0;
  bit           hold_req  = 1'b0;
  sobel_tracker trk       = new();

  sobel_edge_threshold i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) trk.match_pixel(pixel_out, frame_last);
  end

  // Output back-pressure: short random bursts, or one long hold when asked.
  // The long hold waits until results are due, so the block really fills up.
  initial begin : stall_gen
    int n;
    forever begin
      @(negedge clk);
      if (hold_req && trk.edges_due.size() != 0) begin
        out_stall <= 1'b1;
        for (n = 0; n < 120; n++) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_beat(input logic flush, input logic [PIX_W-1:0] p);
    if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= flush;
    pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.take_beat(flush, p);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (trk.edges_due.size() != 0) @(negedge clk);
    // Beats that give no result may still be in flight; let them clear.
    repeat (8) @(negedge clk);
  endtask

  task automatic poke_reg(input logic idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    trk.write_reg(idx, CFG_W'(val));
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int style);
    case (style)
      0:       return PIX_W'($urandom_range(0, 255));
      1:       return {PIX_W{1'($urandom_range(0, 1))}};
      default: return PIX_W'($urandom_range(96, 160));
    endcase
  endfunction

  task automatic run_frame(input int wreg, input int thr, input int rows, input bit noisy,
                           input int style);
    int len;
    int r;
    int k;
    bit flush;
    settle_block();
    poke_reg(REG_IMAGE_WIDTH, wreg);
    poke_reg(REG_EDGE_THRESHOLD, thr);
    len = trk.row_length();
    for (r = 0; r <= rows; r++) begin
      for (k = 0; k < len; k++) begin
        // The final pass is the replicated bottom row, sent as flush ticks.
        flush = (r == rows);
        if (noisy && $urandom_range(99) < 6) flush = !flush;
        if (noisy && $urandom_range(99) < 3)
          push_beat(1'($urandom_range(0, 1)), pick_pixel(style));
        push_beat(flush, pick_pixel(style));
      end
    end
    // A broken frame can stop anywhere: finish the first row, or flush out the rest.
    while (trk.stage != PH_EMPTY || trk.column != 0)
      push_beat(trk.stage != PH_EMPTY, pick_pixel(style));
  endtask

  initial begin : stimulus
    int base;
    int k;
    int wreg;
    int thr;
    int sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Width below the minimum acts as two columns; threshold zero marks every pixel.
    poke_reg(REG_IMAGE_WIDTH, 1);
    poke_reg(REG_EDGE_THRESHOLD, 0);
    push_beat(1'b1, 8'hA5);
    push_beat(1'b0, 8'h00);
    push_beat(1'b0, 8'hFF);
    push_beat(1'b0, 8'hFF);
    push_beat(1'b0, 8'h00);
    push_beat(1'b1, 8'h00);
    push_beat(1'b1, 8'h00);

    // Top threshold, then the width lowered partway through the second row.
    settle_block();
    poke_reg(REG_IMAGE_WIDTH, 5);
    poke_reg(REG_EDGE_THRESHOLD, 1443);
    for (k = 0; k < 5; k++) push_beat(1'b0, (k % 2) ? 8'hFF : 8'h00);
    for (k = 0; k < 3; k++) push_beat(1'b0, (k % 2) ? 8'h00 : 8'hFF);
    settle_block();
    poke_reg(REG_IMAGE_WIDTH, 3);
    push_beat(1'b0, 8'h5A);
    // A pixel beat among the flush ticks; the row still ends on a flush.
    push_beat(1'b1, 8'h00);
    push_beat(1'b0, 8'hC3);
    push_beat(1'b1, 8'h00);

    // A wider frame, with one long output hold so the input side backs up.
    gap_pct   = 10;
    stall_pct = 10;
    hold_req  = 1'b1;
    run_frame(64, 60, 2, 1'b0, 0);

    base = trk.beats;
    while (trk.beats - base < 620) begin
      if (trk.beats - base > 500) calm = 1'b1;
      gap_pct   = 15 * $urandom_range(0, 2);
      stall_pct = 15 * $urandom_range(0, 2);
      sel = $urandom_range(99);
      if (sel < 4) wreg = $urandom_range(0, 1);
      else if (sel < 10) wreg = $urandom_range(13, 40);
      else wreg = $urandom_range(2, 12);
      sel = $urandom_range(99);
      if (sel < 10) thr = 0;
      else if (sel < 15) thr = 1443;
      else if (sel < 20) thr = 1442;
      else if (sel < 25) thr = 1;
      else if (sel < 65) thr = $urandom_range(0, 120);
      else thr = $urandom_range(0, 1443);
      run_frame(wreg, thr, $urandom_range(1, 4), $urandom_range(99) < 20,
                $urandom_range(0, 2));
    end

    in_valid <= 1'b0;
    for (k = 0; k < 4000 && trk.edges_due.size() != 0; k++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (trk.edges_due.size() != 0)
      trk.complain($sformatf("%0d expected results never came", trk.edges_due.size()));
    if (trk.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
